@@ sv/lcd_nibble_bus_sequencer_core_defines.svh @@
// assertion helpers shared by the sequencer modules
`ifndef LCD_NIBBLE_BUS_SEQUENCER_CORE_DEFINES_SVH
`define LCD_NIBBLE_BUS_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LNS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcd sequencer check failed");

// next-cycle implication, checked out of reset
`define LNS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcd sequencer check failed");

`endif

@@ sv/lns_pkg.sv @@
// ----------------------------------------------------------------------------
// lns_pkg
// Types, codes and the power-up table of the 4-bit character-LCD sequencer.
// ----------------------------------------------------------------------------
package lns_pkg;

    localparam logic [2:0] KIND_INIT    = 3'd0;
    localparam logic [2:0] KIND_CMD     = 3'd1;
    localparam logic [2:0] KIND_CHR     = 3'd2;
    localparam logic [2:0] KIND_CUR     = 3'd3;
    localparam logic [2:0] KIND_CUR_CHR = 3'd4;

    localparam logic [7:0] ROW_TOP     = 8'd1;
    localparam logic [7:0] ROW_BOTTOM  = 8'd2;
    localparam logic [7:0] ADDR_TOP    = 8'h80;
    localparam logic [7:0] ADDR_BOTTOM = 8'hC0;

    localparam logic [3:0] LAST_INIT_STEP = 4'd10;
    localparam logic [9:0] EPU_RESET      = 10'd50;

    localparam logic [14:0] WAIT_POWER_UP = 15'd30000;
    localparam logic [14:0] WAIT_LONG     = 15'd5000;
    localparam logic [14:0] WAIT_SHORT    = 15'd150;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [7:0] row;
        logic [7:0] col;
    } t_req;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic        strobe_res;
        logic [14:0] wait_after_us;
        logic        last;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_CMD_HI,
        S_CMD_LO,
        S_CHR_HI,
        S_CHR_LO
    } t_state;

    typedef struct packed {
        logic       load;
        logic       emit;
        t_state     sel;
        logic [3:0] step;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       row_ok;
        logic       out_free;
    } t_status;

    function automatic logic [3:0] init_nibble(input logic [3:0] step);
        logic [3:0] nib;
        case (step)
            4'd1, 4'd2, 4'd3: nib = 4'h3;
            4'd4, 4'd5:       nib = 4'h2;
            4'd6:             nib = 4'h8;
            4'd8:             nib = 4'hC;
            4'd10:            nib = 4'h6;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [14:0] init_wait(input logic [3:0] step, input logic [9:0] epu);
        logic [14:0] w;
        case (step)
            4'd0:    w = WAIT_POWER_UP + {5'd0, epu};
            4'd1:    w = WAIT_LONG;
            4'd2:    w = WAIT_SHORT;
            default: w = 15'd0;
        endcase
        return w;
    endfunction

endpackage

@@ sv/lns_ctrl.sv @@
// ----------------------------------------------------------------------------
// lns_ctrl
// Sequencer state machine: walks the transfers of one request.
// ----------------------------------------------------------------------------
`include "lcd_nibble_bus_sequencer_core_defines.svh"

module lns_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lns_pkg::t_status i_status,
    output lns_pkg::t_cmd    o_cmd
);

    lns_pkg::t_state r_state, n_state;
    logic [3:0]      r_step, n_step;
    logic            r_then_chr, n_then_chr;
    logic            load, emit;

    assign load = i_in_valid && (r_state == lns_pkg::S_IDLE);
    assign emit = (r_state != lns_pkg::S_IDLE) && i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lns_pkg::S_IDLE;
            r_step     <= 4'd0;
            r_then_chr <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_then_chr <= n_then_chr;
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_then_chr = r_then_chr;
        unique case (r_state)
            lns_pkg::S_IDLE: begin
                if (load) begin
                    n_step     = 4'd0;
                    n_then_chr = (i_status.kind == lns_pkg::KIND_CUR_CHR);
                    unique case (i_status.kind)
                        lns_pkg::KIND_INIT: n_state = lns_pkg::S_INIT;
                        lns_pkg::KIND_CMD:  n_state = lns_pkg::S_CMD_HI;
                        lns_pkg::KIND_CHR:  n_state = lns_pkg::S_CHR_HI;
                        lns_pkg::KIND_CUR: begin
                            n_state = i_status.row_ok ? lns_pkg::S_CMD_HI : lns_pkg::S_IDLE;
                        end
                        lns_pkg::KIND_CUR_CHR: begin
                            n_state = i_status.row_ok ? lns_pkg::S_CMD_HI : lns_pkg::S_CHR_HI;
                        end
                        default: n_state = lns_pkg::S_IDLE;
                    endcase
                end
            end
            lns_pkg::S_INIT: begin
                if (emit) begin
                    n_step = r_step + 4'd1;
                    if (r_step == lns_pkg::LAST_INIT_STEP) begin
                        n_state = lns_pkg::S_IDLE;
                    end
                end
            end
            lns_pkg::S_CMD_HI: begin
                if (emit) begin
                    n_state = lns_pkg::S_CMD_LO;
                end
            end
            lns_pkg::S_CMD_LO: begin
                if (emit) begin
                    n_state = r_then_chr ? lns_pkg::S_CHR_HI : lns_pkg::S_IDLE;
                end
            end
            lns_pkg::S_CHR_HI: begin
                if (emit) begin
                    n_state = lns_pkg::S_CHR_LO;
                end
            end
            lns_pkg::S_CHR_LO: begin
                if (emit) begin
                    n_state = lns_pkg::S_IDLE;
                end
            end
            default: n_state = lns_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state == lns_pkg::S_IDLE);
        o_cmd.load = load;
        o_cmd.emit = emit;
        o_cmd.sel  = r_state;
        o_cmd.step = r_step;
        unique case (r_state)
            lns_pkg::S_INIT:   o_cmd.last = (r_step == lns_pkg::LAST_INIT_STEP);
            lns_pkg::S_CMD_LO: o_cmd.last = !r_then_chr;
            lns_pkg::S_CHR_LO: o_cmd.last = 1'b1;
            default:           o_cmd.last = 1'b0;
        endcase
    end

    `LNS_ASSERT_NOW(a_step_range, r_state == lns_pkg::S_INIT, r_step <= lns_pkg::LAST_INIT_STEP)
    `LNS_ASSERT_NEXT(a_last_ends, emit && o_cmd.last, r_state == lns_pkg::S_IDLE)
    `LNS_ASSERT_NOW(a_load_no_emit, load, !emit)

endmodule

@@ sv/lns_dpath.sv @@
// ----------------------------------------------------------------------------
// lns_dpath
// Request registers, enable-time register, transfer formation and output
// register of the sequencer.
// ----------------------------------------------------------------------------
`include "lcd_nibble_bus_sequencer_core_defines.svh"

module lns_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lns_pkg::t_req    i_req,
    input  logic             i_cfg_we,
    input  logic [9:0]       i_cfg_data,
    input  lns_pkg::t_cmd    i_cmd,
    output lns_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lns_pkg::t_rsp    o_out_rsp
);

    logic [9:0]    r_epu;
    logic [7:0]    r_cmd_byte;
    logic [7:0]    r_chr;
    logic          r_valid;
    lns_pkg::t_rsp r_out;
    lns_pkg::t_rsp n_out;
    logic [7:0]    cur_base;
    logic [7:0]    cur_addr;

    assign cur_base = (i_req.row == lns_pkg::ROW_TOP) ? lns_pkg::ADDR_TOP : lns_pkg::ADDR_BOTTOM;
    assign cur_addr = cur_base + i_req.col - 8'd1;

    assign o_status.kind     = i_req.kind;
    assign o_status.row_ok   = (i_req.row == lns_pkg::ROW_TOP)
                            || (i_req.row == lns_pkg::ROW_BOTTOM);
    assign o_status.out_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epu   <= lns_pkg::EPU_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_epu <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_byte <= (i_req.kind == lns_pkg::KIND_CMD) ? i_req.value : cur_addr;
            r_chr      <= i_req.value;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    // transfer for the current sequencer step
    always_comb begin
        n_out.last = i_cmd.last;
        unique case (i_cmd.sel)
            lns_pkg::S_INIT: begin
                n_out.reg_select    = 1'b0;
                n_out.nibble        = lns_pkg::init_nibble(i_cmd.step);
                n_out.strobe_res    = (i_cmd.step != 4'd0);
                n_out.wait_after_us = lns_pkg::init_wait(i_cmd.step, r_epu);
            end
            lns_pkg::S_CMD_HI: begin
                n_out.reg_select    = 1'b0;
                n_out.nibble        = r_cmd_byte[7:4];
                n_out.strobe_res    = 1'b1;
                n_out.wait_after_us = 15'd0;
            end
            lns_pkg::S_CMD_LO: begin
                n_out.reg_select    = 1'b0;
                n_out.nibble        = r_cmd_byte[3:0];
                n_out.strobe_res    = 1'b1;
                n_out.wait_after_us = 15'd0;
            end
            lns_pkg::S_CHR_HI: begin
                n_out.reg_select    = 1'b1;
                n_out.nibble        = r_chr[7:4];
                n_out.strobe_res    = 1'b1;
                n_out.wait_after_us = {5'd0, r_epu};
            end
            lns_pkg::S_CHR_LO: begin
                n_out.reg_select    = 1'b1;
                n_out.nibble        = r_chr[3:0];
                n_out.strobe_res    = 1'b1;
                n_out.wait_after_us = {5'd0, r_epu};
            end
            default: begin
                n_out.reg_select    = 1'b0;
                n_out.nibble        = 4'd0;
                n_out.strobe_res    = 1'b0;
                n_out.wait_after_us = 15'd0;
            end
        endcase
    end

    assign o_out_valid = r_valid;
    assign o_out_rsp   = r_out;

    `LNS_ASSERT_NOW(a_no_overwrite, i_cmd.emit, !r_valid || i_out_ready)

endmodule

@@ sv/lcd_nibble_bus_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// lcd_nibble_bus_sequencer_core
// Expands each request into the nibble transfers of a 4-bit character-LCD bus.
//
//   channel   direction   handshake                    payload
//   request   in          i_in_valid / o_in_ready      i_in_req   (t_req)
//   transfer  out         o_out_valid / i_out_ready    o_out_rsp  (t_rsp)
//   config    in          i_cfg_we                     i_cfg_data (enable time, us)
//
// ready only when idle; once a request is taken, one transfer is formed per
// cycle while the output is free: init 11 transfers, command or character 2,
// cursor then character 4; requests with no transfer leave the sequencer idle
// the output register lets the last transfer wait while the next request enters
// a stalled output holds the sequencer on its current step
// reset clears the state machine and output valid, and loads enable time 50
// ----------------------------------------------------------------------------
module lcd_nibble_bus_sequencer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lns_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lns_pkg::t_rsp o_out_rsp,
    input  logic          i_cfg_we,
    input  logic [9:0]    i_cfg_data
);

    lns_pkg::t_cmd    cmd;
    lns_pkg::t_status status;

    lns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lns_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule
